FILE: src/cbrb_pkg.sv
// package for the caption block reorder buffer
// holds sizes, codes and the byte-check helper; no dependencies
package cbrb_pkg;

  localparam int SideSlots   = 3;
  localparam int SlotEntries = 9;
  localparam int NumSlots    = 2 * SideSlots + 1;
  localparam int NumEntries  = NumSlots * SlotEntries;
  localparam int SlotW       = $clog2(NumSlots);
  localparam int EntryW      = $clog2(SlotEntries);
  localparam int FillW       = $clog2(SlotEntries + 1);
  localparam int AddrW       = $clog2(NumEntries);

  localparam logic [1:0] OpStore  = 2'd0;
  localparam logic [1:0] OpFlush  = 2'd1;
  localparam logic [1:0] OpAnchor = 2'd2;
  localparam logic [1:0] OpSpare  = 2'd3;

  localparam logic [1:0] RegAppend  = 2'd0;
  localparam logic [1:0] RegFixPad  = 2'd1;
  localparam logic [1:0] RegSkipNul = 2'd2;

  localparam logic [7:0] ByteSub    = 8'h7F;
  localparam logic [7:0] BytePad    = 8'h80;
  localparam logic [7:0] HdrNullA   = 8'hFA;
  localparam logic [7:0] HdrNullC   = 8'hFC;
  localparam logic [7:0] HdrNullD   = 8'hFD;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } state_t;

  function automatic logic odd_par(input logic [7:0] b);
    odd_par = ^b;
  endfunction

endpackage

FILE: src/cbrb_ram.sv
// generic single-port-write, single-read ram with registered read
// no dependencies
module cbrb_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: src/caption_block_reorder_buffer_unit.sv
// top level of the caption block reorder buffer
// uses cbrb_pkg and cbrb_ram for triplet storage
//
// A store inside the slot window is written when accepted, and the block takes the
// next request right after it. A flush, and a store outside the slot window, reads
// the filled entries of the 63-entry triplet memory one per cycle (an empty slot
// still takes a scan step; one read port, registered read) and emits each surviving
// triplet on the strobe for one cycle. Busy stays high through the READ and EMIT
// states; an out-of-range store is written in EMIT. Results cannot be held off.
// Slot fills and timestamps sit in flip-flops and clear at the end of a flush.
module caption_block_reorder_buffer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation,
  input  logic [15:0] seq_number,
  input  logic [39:0] timestamp,
  input  logic        first_of_packet,
  input  logic [7:0]  header_byte,
  input  logic [7:0]  data_byte_one,
  input  logic [7:0]  data_byte_two,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic        cfg_data,
  output logic        strobe,
  output logic [1:0]  block_kind,
  output logic        block_valid,
  output logic [7:0]  out_byte_one,
  output logic [7:0]  out_byte_two,
  output logic [39:0] out_time,
  output logic        last
);

  localparam logic [cbrb_pkg::SlotW-1:0]  LastSlot  = cbrb_pkg::SlotW'(cbrb_pkg::NumSlots - 1);
  localparam logic [cbrb_pkg::EntryW-1:0] LastEntry =
    cbrb_pkg::EntryW'(cbrb_pkg::SlotEntries - 1);

  logic append_mode, zero_pad_en, skip_null_payload;
  logic [15:0] anchor_seq;
  logic        anchor_known;
  logic [cbrb_pkg::FillW-1:0] slot_fill [cbrb_pkg::NumSlots];
  logic [39:0]                slot_time [cbrb_pkg::NumSlots];

  cbrb_pkg::state_t state, state_next;

  // pending store held while the flush for an out-of-range store runs
  logic        pend;
  logic [39:0] pend_ts;
  logic        pend_first;
  logic [23:0] pend_trip;

  // scan position and the entry in flight through the read
  logic [cbrb_pkg::SlotW-1:0]  scan_slot;
  logic [cbrb_pkg::EntryW-1:0] scan_ent;
  logic                        scan_done;
  logic                        rd_live;
  logic [cbrb_pkg::SlotW-1:0]  rd_slot;

  // one result held back so last can be marked
  logic        hold_v;
  logic [1:0]  hold_kind;
  logic        hold_valid;
  logic [7:0]  hold_b1, hold_b2;
  logic [39:0] hold_time;

  logic                        we;
  logic [cbrb_pkg::AddrW-1:0]  waddr, raddr;
  logic [23:0]                 wdata, rdata;

  cbrb_ram #(.Width(24), .Depth(cbrb_pkg::NumEntries)) u_trip (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign cfg_ready = (state == cbrb_pkg::ST_IDLE);
  assign busy      = (state != cbrb_pkg::ST_IDLE);
  logic accept;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      append_mode       <= 1'b0;
      zero_pad_en       <= 1'b0;
      skip_null_payload <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cbrb_pkg::RegAppend:  append_mode       <= cfg_data;
        cbrb_pkg::RegFixPad:  zero_pad_en       <= cfg_data;
        cbrb_pkg::RegSkipNul: skip_null_payload <= cfg_data;
        default: ;
      endcase
    end
  end

  // store path: slot index from offset to anchor
  logic [15:0] eff_anchor;
  logic [17:0] diff;
  logic        in_range;
  logic [cbrb_pkg::SlotW-1:0] st_slot;
  assign eff_anchor = anchor_known ? anchor_seq : seq_number;
  assign diff = {2'b00, seq_number} - {2'b00, eff_anchor} + 18'(cbrb_pkg::SideSlots);
  assign in_range = !diff[17] && (diff <= 18'(2 * cbrb_pkg::SideSlots));
  assign st_slot = diff[cbrb_pkg::SlotW-1:0];

  // store that completes now: fresh in-range store, or pending after flush
  logic        do_store;
  logic [cbrb_pkg::SlotW-1:0] ds_slot;
  logic [39:0] ds_ts;
  logic        ds_first;
  logic [23:0] ds_trip;
  logic [cbrb_pkg::FillW-1:0] ds_fill;
  logic        flush_end;

  always_comb begin
    do_store = 1'b0;
    ds_slot  = st_slot;
    ds_ts    = timestamp;
    ds_first = first_of_packet;
    ds_trip  = {header_byte, data_byte_one, data_byte_two};
    if (flush_end && pend) begin
      do_store = 1'b1;
      ds_slot  = cbrb_pkg::SlotW'(cbrb_pkg::SideSlots);
      ds_ts    = pend_ts;
      ds_first = pend_first;
      ds_trip  = pend_trip;
    end else if (accept && operation == cbrb_pkg::OpStore && in_range) begin
      do_store = 1'b1;
    end
    // the slots are being cleared when the pending store lands
    if ((!append_mode && ds_first) || (flush_end && pend)) ds_fill = '0;
    else ds_fill = slot_fill[ds_slot];
  end

  assign we    = do_store && (ds_fill < cbrb_pkg::FillW'(cbrb_pkg::SlotEntries));
  assign waddr = cbrb_pkg::AddrW'(ds_slot * cbrb_pkg::SlotEntries + ds_fill);
  assign wdata = ds_trip;
  assign raddr = cbrb_pkg::AddrW'(scan_slot * cbrb_pkg::SlotEntries + scan_ent);

  logic start_flush;
  assign start_flush = accept && (operation == cbrb_pkg::OpFlush ||
                       (operation == cbrb_pkg::OpStore && !in_range));
  assign flush_end = (state == cbrb_pkg::ST_EMIT) && !rd_live;

  always_comb begin
    state_next = state;
    case (state)
      cbrb_pkg::ST_IDLE: if (start_flush) state_next = cbrb_pkg::ST_READ;
      cbrb_pkg::ST_READ: if (scan_done)   state_next = cbrb_pkg::ST_EMIT;
      cbrb_pkg::ST_EMIT: if (!rd_live)    state_next = cbrb_pkg::ST_IDLE;
      default:           state_next = cbrb_pkg::ST_IDLE;
    endcase
  end

  // filter of the entry read last cycle
  logic [7:0] f_hdr, f_b1, f_b2;
  logic       f_valid, f_keep;
  logic [1:0] f_type;
  always_comb begin
    f_hdr   = rdata[23:16];
    f_b1    = rdata[15:8];
    f_b2    = rdata[7:0];
    f_valid = f_hdr[2];
    f_type  = f_hdr[1:0];
    f_keep  = 1'b1;
    if (f_valid && !f_type[1]) begin
      if (!cbrb_pkg::odd_par(f_b2)) f_keep = 1'b0;
      if (!cbrb_pkg::odd_par(f_b1)) f_b1 = cbrb_pkg::ByteSub;
    end
    if (zero_pad_en && !f_valid && !f_type[1] && f_b1 == 8'h00 && f_b2 == 8'h00) begin
      f_valid = 1'b1;
      f_b1    = cbrb_pkg::BytePad;
      f_b2    = cbrb_pkg::BytePad;
    end
    if (skip_null_payload && (f_hdr == cbrb_pkg::HdrNullA || f_hdr == cbrb_pkg::HdrNullC ||
        f_hdr == cbrb_pkg::HdrNullD) && f_b1[6:0] == 7'd0 && f_b2[6:0] == 7'd0)
      f_keep = 1'b0;
    if (!(f_valid || f_type == 2'd3)) f_keep = 1'b0;
    f_keep = f_keep && rd_live;
  end

  logic emit_now;
  assign emit_now = hold_v && (f_keep || flush_end);

  always_comb begin
    strobe       = emit_now;
    block_kind   = hold_kind;
    block_valid  = hold_valid;
    out_byte_one = hold_b1;
    out_byte_two = hold_b2;
    out_time     = hold_time;
    last         = flush_end;
  end

  // next scan position skips slots past their fill
  logic [cbrb_pkg::SlotW-1:0]  nx_slot;
  logic [cbrb_pkg::EntryW-1:0] nx_ent;
  logic                        nx_done;
  always_comb begin
    nx_slot = scan_slot;
    nx_ent  = scan_ent + 1'b1;
    nx_done = 1'b0;
    if (scan_ent == LastEntry ||
        cbrb_pkg::FillW'(scan_ent) + 1'b1 >= slot_fill[scan_slot]) begin
      nx_ent = '0;
      if (scan_slot == LastSlot) nx_done = 1'b1;
      else nx_slot = scan_slot + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= cbrb_pkg::ST_IDLE;
      anchor_seq   <= '0;
      anchor_known <= 1'b0;
      pend         <= 1'b0;
      scan_slot    <= '0;
      scan_ent     <= '0;
      scan_done    <= 1'b0;
      rd_live      <= 1'b0;
      hold_v       <= 1'b0;
      for (int i = 0; i < cbrb_pkg::NumSlots; i++) begin
        slot_fill[i] <= '0;
        slot_time[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (accept && operation == cbrb_pkg::OpAnchor) begin
        anchor_seq   <= seq_number;
        anchor_known <= 1'b1;
      end
      if (accept && operation == cbrb_pkg::OpStore) begin
        anchor_known <= 1'b1;
        if (!anchor_known || !in_range) anchor_seq <= seq_number;
      end
      if (start_flush) begin
        pend       <= (operation == cbrb_pkg::OpStore);
        pend_ts    <= timestamp;
        pend_first <= first_of_packet;
        pend_trip  <= {header_byte, data_byte_one, data_byte_two};
        scan_slot  <= '0;
        scan_ent   <= '0;
        scan_done  <= 1'b0;
        hold_v     <= 1'b0;
      end
      // scan: present an address each cycle while not done
      rd_live <= (state == cbrb_pkg::ST_READ) && !scan_done &&
                 (slot_fill[scan_slot] != '0);
      rd_slot <= scan_slot;
      if (state == cbrb_pkg::ST_READ && !scan_done) begin
        scan_slot <= nx_slot;
        scan_ent  <= nx_ent;
        scan_done <= nx_done;
      end
      if (f_keep) begin
        hold_v     <= 1'b1;
        hold_kind  <= f_type;
        hold_valid <= f_valid;
        hold_b1    <= f_b1;
        hold_b2    <= f_b2;
        hold_time  <= slot_time[rd_slot];
      end
      if (flush_end) begin
        hold_v <= 1'b0;
        pend   <= 1'b0;
      end
      // a store into a slot wins over the clear at the end of a flush
      for (int i = 0; i < cbrb_pkg::NumSlots; i++) begin
        if (do_store && ds_slot == cbrb_pkg::SlotW'(i)) begin
          slot_time[i] <= ds_ts;
          slot_fill[i] <= we ? ds_fill + 1'b1 : ds_fill;
        end else if (flush_end) begin
          slot_fill[i] <= '0;
          slot_time[i] <= '0;
        end
      end
    end
  end

  a_busy_no_cfg: assert property (@(posedge clk) disable iff (rst)
    busy |-> !cfg_ready) else $error("config taken while busy");
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy) else $error("result outside flush");
  a_last_strobe: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |=> !busy) else $error("flush did not end after last");
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    slot_fill[cbrb_pkg::SideSlots] <= cbrb_pkg::FillW'(cbrb_pkg::SlotEntries))
    else $error("slot overfilled");

endmodule

FILE: tb/caption_block_reorder_buffer_unit_tb.sv
`timescale 1ns / 100ps
// testbench for the caption block reorder buffer: directed table, then random requests
// depends on cbrb_pkg and caption_block_reorder_buffer_unit
module caption_block_reorder_buffer_unit_tb;

  typedef struct packed {
    logic [1:0]  kind;
    logic        valid;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [39:0] ts;
    logic        fin;
  } block_t;

  typedef struct {
    logic [1:0]  op;
    logic [15:0] seq;
    logic [39:0] ts;
    logic        first;
    logic [7:0]  hdr;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic        typed;
    block_t      blk;
  } row_t;

  logic clk = 0, rst = 1;
  logic start = 0;
  logic busy;
  logic [1:0] operation = 0;
  logic [15:0] seq_number = 0;
  logic [39:0] timestamp = 0;
  logic first_of_packet = 0;
  logic [7:0] header_byte = 0, data_byte_one = 0, data_byte_two = 0;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [1:0] cfg_index = 0;
  logic cfg_data = 0;
  logic strobe;
  logic [1:0] block_kind;
  logic block_valid;
  logic [7:0] out_byte_one, out_byte_two;
  logic [39:0] out_time;
  logic last;

  caption_block_reorder_buffer_unit u_dut (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  // shadow of the buffer
  logic [15:0] anchor;
  logic        anchored;
  logic [3:0]  fill [cbrb_pkg::NumSlots];
  logic [39:0] stamp [cbrb_pkg::NumSlots];
  logic [23:0] trip [cbrb_pkg::NumEntries];
  logic        app_m, pad_m, skip_m;

  block_t pending_blocks[$];
  block_t typed_blocks[$];
  int errors = 0;
  int idle_pct = 0;

  function automatic logic odd8(logic [7:0] b);
    int n;
    n = 0;
    for (int i = 0; i < 8; i++) n += b[i];
    return n[0];
  endfunction

  task automatic drain_slots();
    logic [7:0] h, x, y;
    logic v;
    int n;
    block_t b;
    n = 0;
    for (int s = 0; s < cbrb_pkg::NumSlots; s++) begin
      for (int e = 0; e < fill[s] && e < cbrb_pkg::SlotEntries; e++) begin
        h = trip[s * cbrb_pkg::SlotEntries + e][23:16];
        x = trip[s * cbrb_pkg::SlotEntries + e][15:8];
        y = trip[s * cbrb_pkg::SlotEntries + e][7:0];
        v = h[2];
        if (v && h[1:0] <= 1) begin
          if (!odd8(y)) continue;
          if (!odd8(x)) x = cbrb_pkg::ByteSub;
        end
        if (pad_m && !v && h[1:0] <= 1 && x == 0 && y == 0) begin
          v = 1; x = cbrb_pkg::BytePad; y = cbrb_pkg::BytePad;
        end
        if (skip_m && (h == cbrb_pkg::HdrNullA || h == cbrb_pkg::HdrNullC ||
            h == cbrb_pkg::HdrNullD) && x[6:0] == 0 && y[6:0] == 0) continue;
        if (!(v || h[1:0] == 2'd3)) continue;
        b = '{h[1:0], v, x, y, stamp[s], 1'b0};
        pending_blocks.push_back(b);
        n++;
      end
    end
    if (n > 0) pending_blocks[pending_blocks.size() - 1].fin = 1;
    for (int s = 0; s < cbrb_pkg::NumSlots; s++) begin
      fill[s] = 0; stamp[s] = 0;
    end
  endtask

  task automatic predict(row_t r);
    int idx;
    if (r.op == cbrb_pkg::OpFlush) drain_slots();
    else if (r.op == cbrb_pkg::OpAnchor) begin
      anchor = r.seq; anchored = 1;
    end else if (r.op == cbrb_pkg::OpStore) begin
      if (!anchored) begin
        anchor = r.seq; anchored = 1;
      end
      idx = int'(r.seq) - int'(anchor) + cbrb_pkg::SideSlots;
      if (idx < 0 || idx > 2 * cbrb_pkg::SideSlots) begin
        drain_slots();
        anchor = r.seq;
        idx = cbrb_pkg::SideSlots;
      end
      stamp[idx] = r.ts;
      if (!app_m && r.first) fill[idx] = 0;
      if (fill[idx] < cbrb_pkg::SlotEntries) begin
        trip[idx * cbrb_pkg::SlotEntries + fill[idx]] = {r.hdr, r.b1, r.b2};
        fill[idx]++;
      end
    end
  endtask

  always @(posedge clk) begin
    block_t got, want;
    if (!rst && strobe) begin
      got = '{block_kind, block_valid, out_byte_one, out_byte_two, out_time, last};
      if (pending_blocks.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected block %p", got);
      end else begin
        want = pending_blocks.pop_front();
        if (typed_blocks.size() > 0) begin
          // typed-in row result must agree with predictor too
          if (typed_blocks.pop_front() != want) begin
            errors++;
            if (errors <= 10) $display("table row disagrees with predictor %p", want);
          end
        end
        if (got != want) begin
          errors++;
          if (errors <= 10) $display("block exp %p got %p", want, got);
        end
      end
    end
  end

  // entered at a falling edge; returns at the falling edge after the accept
  task automatic send(row_t r);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 0;
      @(negedge clk);
    end
    operation <= r.op; seq_number <= r.seq; timestamp <= r.ts;
    first_of_packet <= r.first; header_byte <= r.hdr;
    data_byte_one <= r.b1; data_byte_two <= r.b2;
    start <= 1;
    while (busy) @(negedge clk);
    @(posedge clk);
    predict(r);
    if (r.typed) typed_blocks.push_back(r.blk);
    @(negedge clk);
  endtask

  task automatic settle();
    int guard;
    guard = 0;
    start <= 0;
    while (pending_blocks.size() > 0 && guard < 5000) begin
      @(negedge clk); guard++;
    end
    repeat (80) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] index, logic val);
    cfg_index <= index; cfg_data <= val; cfg_valid <= 1;
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    case (index)
      cbrb_pkg::RegAppend:  app_m = val;
      cbrb_pkg::RegFixPad:  pad_m = val;
      cbrb_pkg::RegSkipNul: skip_m = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  function automatic row_t mk(logic [1:0] op, logic [15:0] seq, logic [39:0] ts,
                              logic first, logic [7:0] h, logic [7:0] x, logic [7:0] y);
    row_t r;
    r = '{op, seq, ts, first, h, x, y, 1'b0, '0};
    return r;
  endfunction

  function automatic row_t rand_store(logic [15:0] base);
    logic [7:0] h;
    logic [15:0] s;
    h = 8'($urandom_range(255));
    if ($urandom_range(3) != 0) h = {5'b11111, $urandom_range(1) ? 3'b100 : 3'b101};
    if ($urandom_range(7) == 0) h = $urandom_range(1) ? cbrb_pkg::HdrNullA : cbrb_pkg::HdrNullC;
    s = ($urandom_range(9) == 0) ? 16'($urandom) : 16'(base + $urandom_range(6) - 3);
    return mk(cbrb_pkg::OpStore, s, 40'({$urandom, $urandom}), $urandom_range(3) == 0, h,
              ($urandom_range(7) == 0) ? 8'h00 : 8'($urandom),
              ($urandom_range(7) == 0) ? 8'h80 : 8'($urandom));
  endfunction

  row_t dir_rows[$];

  initial begin
    row_t r;
    logic [15:0] base;
    anchored = 0; anchor = 0;
    app_m = 0; pad_m = 0; skip_m = 1;
    for (int s = 0; s < cbrb_pkg::NumSlots; s++) begin
      fill[s] = 0; stamp[s] = 0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: flush on empty, extremes, parity cases, window edges, slot overfill, out-of-window store, spare op
    dir_rows.push_back(mk(cbrb_pkg::OpFlush, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(cbrb_pkg::OpStore, 16'hFFFF, 40'hFF_FFFF_FFFF, 1, 8'hFC,
                          8'h01, 8'h01));
    dir_rows.push_back(mk(cbrb_pkg::OpFlush, 0, 0, 0, 0, 0, 0));
    r = dir_rows[2]; r.typed = 1;
    r.blk = '{2'd0, 1'b1, 8'h01, 8'h01, 40'hFF_FFFF_FFFF, 1'b1};
    dir_rows[2] = r;
    dir_rows.push_back(mk(cbrb_pkg::OpAnchor, 16'd100, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(cbrb_pkg::OpStore, 16'd97, 40'd5, 1, 8'hFC, 8'h00, 8'h01));
    dir_rows.push_back(mk(cbrb_pkg::OpStore, 16'd103, 40'd6, 1, 8'hFD, 8'h01, 8'h00));
    dir_rows.push_back(mk(cbrb_pkg::OpStore, 16'd100, 40'd7, 1, 8'hFE, 8'h00, 8'h00));
    dir_rows.push_back(mk(cbrb_pkg::OpStore, 16'd100, 40'd8, 0, 8'hFF, 8'hAA, 8'h55));
    dir_rows.push_back(mk(cbrb_pkg::OpStore, 16'd101, 40'd9, 1, 8'hF8, 8'h00, 8'h00));
    dir_rows.push_back(mk(cbrb_pkg::OpStore, 16'd101, 40'd9, 0, 8'hFA, 8'h80, 8'h80));
    dir_rows.push_back(mk(cbrb_pkg::OpStore, 16'd102, 40'd9, 0, 8'h03, 8'hFF, 8'hFF));
    for (int i = 0; i < 10; i++)
      dir_rows.push_back(mk(cbrb_pkg::OpStore, 16'd99, 40'(i), 0, 8'hFD, 8'(i), 8'h01));
    dir_rows.push_back(mk(cbrb_pkg::OpStore, 16'd0, 40'd1, 1, 8'hFC, 8'h01, 8'h01));
    dir_rows.push_back(mk(cbrb_pkg::OpStore, 16'd0, 40'd2, 1, 8'hFC, 8'hFE, 8'h02));
    dir_rows.push_back(mk(cbrb_pkg::OpSpare, 16'd0, 40'd0, 0, 8'hFC, 8'h01, 8'h01));
    dir_rows.push_back(mk(cbrb_pkg::OpFlush, 0, 0, 0, 0, 0, 0));
    foreach (dir_rows[i]) send(dir_rows[i]);
    settle();

    base = 16'd500;
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(cbrb_pkg::RegAppend, ph[0]);
      write_reg(cbrb_pkg::RegFixPad, ph[1]);
      write_reg(cbrb_pkg::RegSkipNul, ph[2] ^ ph[0]);
      cfg_valid <= 0;
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 60;
        2: idle_pct = 23;
        default: idle_pct = 0;
      endcase
      for (int i = 0; i < 50; i++) begin
        if ($urandom_range(15) == 0) r = mk(cbrb_pkg::OpFlush, 0, 0, 0, 0, 0, 0);
        else if ($urandom_range(40) == 0)
          r = mk(cbrb_pkg::OpAnchor, 16'($urandom), 0, 0, 0, 0, 0);
        else r = rand_store(base);
        if (r.op == cbrb_pkg::OpAnchor) base = r.seq;
        if (r.op == cbrb_pkg::OpStore && $urandom_range(9) == 0) base = r.seq;
        send(r);
      end
      send(mk(cbrb_pkg::OpFlush, 0, 0, 0, 0, 0, 0));
      settle();
    end

    if (errors == 0 && pending_blocks.size() == 0) begin
      $display("caption_block_reorder_buffer_unit: match");
    end else begin
      $display("caption_block_reorder_buffer_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("caption_block_reorder_buffer_unit: mismatch");
    $finish;
  end

endmodule
